[sv/pfp_pkg.sv]
`default_nettype none
package pfp_pkg;

  // Header layout, byte offsets from the start of the packet
  localparam logic [16:0] HDR_LEN      = 17'd23;
  localparam logic [16:0] OFS_VERSION  = 17'd2;
  localparam logic [16:0] OFS_FLAGS    = 17'd3;
  localparam logic [16:0] OFS_SEQUENCE = 17'd12;
  localparam logic [16:0] OFS_COUNT    = 17'd20;
  localparam logic [16:0] OFS_PAYLEN   = 17'd21;
  localparam logic [16:0] COUNT_MAX    = 17'h1FFFF;
  localparam logic [7:0]  PROTO_VERSION = 8'd1;

  // Result kinds
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_FRAME  = 3'd1;
  localparam logic [2:0] KIND_DATA   = 3'd2;
  localparam logic [2:0] KIND_ACCEPT = 3'd3;
  localparam logic [2:0] KIND_REJECT = 3'd4;

  // Verdict codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SHORT     = 3'd1;
  localparam logic [2:0] ERR_MAGIC     = 3'd2;
  localparam logic [2:0] ERR_VERSION   = 3'd3;
  localparam logic [2:0] ERR_LENGTH    = 3'd4;
  localparam logic [2:0] ERR_FRAME_HDR = 3'd5;
  localparam logic [2:0] ERR_FRAME_DAT = 3'd6;
  localparam logic [2:0] ERR_TRAILING  = 3'd7;

  // Work for one accepted byte: an optional header/frame/data result and an
  // optional verdict, sharing the held header values.
  typedef struct packed {
    logic [7:0]  flags;
    logic [63:0] session_word;
    logic [63:0] sequence_res;
    logic [7:0]  frame_total;
    logic        prim_valid;
    logic [2:0]  prim_kind;
    logic [7:0]  frame_index;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic        verdict_valid;
    logic [2:0]  error_code;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  flags;
    logic [63:0] session_word;
    logic [63:0] sequence_res;
    logic [7:0]  frame_total;
    logic [7:0]  frame_index;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic [2:0]  error_code;
    logic        last_of_run;
  } result_t;

endpackage
`default_nettype wire

[sv/pfp_front.sv]
`default_nettype none
module pfp_front import pfp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_buffer,
  input  wire logic [15:0] magic_value,
  input  wire q_status_t   q_status,
  output logic             push,
  output entry_t           entry
);

  typedef enum logic [1:0] {PH_TYPE, PH_LENHI, PH_LENLO, PH_DATA} phase_t;

  logic [16:0] byte_count, byte_count_next;
  logic [15:0] magic_seen, magic_seen_next;
  logic [7:0]  version_seen, version_seen_next;
  logic [7:0]  flags_held, flags_held_next;
  logic [63:0] session_held, session_held_next;
  logic [63:0] sequence_held, sequence_held_next;
  logic [7:0]  count_held, count_held_next;
  logic [15:0] payload_len_held, payload_len_held_next;
  phase_t      frame_phase, frame_phase_next;
  logic [7:0]  frames_done, frames_done_next;
  logic [15:0] frame_remaining, frame_remaining_next;
  logic [2:0]  first_error, first_error_next;
  logic [7:0]  cur_type, cur_type_next;
  logic [15:0] cur_len, cur_len_next;
  logic        accept;
  logic        end_of_frame;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (entry.prim_valid || entry.verdict_valid);

  always_comb begin
    byte_count_next       = (byte_count != COUNT_MAX) ? byte_count + 17'd1 : byte_count;
    magic_seen_next       = magic_seen;
    version_seen_next     = version_seen;
    flags_held_next       = flags_held;
    session_held_next     = session_held;
    sequence_held_next    = sequence_held;
    count_held_next       = count_held;
    payload_len_held_next = payload_len_held;
    frame_phase_next      = frame_phase;
    frames_done_next      = frames_done;
    frame_remaining_next  = frame_remaining;
    first_error_next      = first_error;
    cur_type_next         = cur_type;
    cur_len_next          = cur_len;
    end_of_frame          = 1'b0;
    entry                 = '0;

    if (byte_count < HDR_LEN) begin
      if (byte_count < OFS_VERSION) begin
        magic_seen_next = {magic_seen[7:0], data_byte};
      end else if (byte_count == OFS_VERSION) begin
        version_seen_next = data_byte;
      end else if (byte_count == OFS_FLAGS) begin
        flags_held_next = data_byte;
      end else if (byte_count < OFS_SEQUENCE) begin
        session_held_next = {session_held[55:0], data_byte};
      end else if (byte_count < OFS_COUNT) begin
        sequence_held_next = {sequence_held[55:0], data_byte};
      end else if (byte_count == OFS_COUNT) begin
        count_held_next = data_byte;
      end else begin
        payload_len_held_next = {payload_len_held[7:0], data_byte};
      end
      if (byte_count == HDR_LEN - 17'd1) begin
        entry.prim_valid = 1'b1;
        entry.prim_kind  = KIND_HEADER;
      end
    end else if (frames_done >= count_held) begin
      // bytes past the last declared frame
      if (first_error == ERR_NONE) begin
        first_error_next = ERR_TRAILING;
      end
    end else begin
      case (frame_phase)
        PH_TYPE: begin
          cur_type_next    = data_byte;
          frame_phase_next = PH_LENHI;
        end
        PH_LENHI: begin
          cur_len_next     = {data_byte, 8'h00};
          frame_phase_next = PH_LENLO;
        end
        PH_LENLO: begin
          cur_len_next       = {cur_len[15:8], data_byte};
          entry.prim_valid   = 1'b1;
          entry.prim_kind    = KIND_FRAME;
          entry.frame_index  = frames_done;
          entry.frame_type   = cur_type;
          entry.frame_length = cur_len_next;
          if (cur_len_next == 16'd0) begin
            frames_done_next = frames_done + 8'd1;
            frame_phase_next = PH_TYPE;
          end else begin
            frame_remaining_next = cur_len_next;
            frame_phase_next     = PH_DATA;
          end
        end
        PH_DATA: begin
          end_of_frame        = (frame_remaining <= 16'd1);
          entry.prim_valid    = 1'b1;
          entry.prim_kind     = KIND_DATA;
          entry.frame_index   = frames_done;
          entry.frame_type    = cur_type;
          entry.frame_length  = cur_len;
          entry.payload_byte  = data_byte;
          entry.last_of_frame = end_of_frame;
          if (end_of_frame) begin
            frame_remaining_next = 16'd0;
            frames_done_next     = frames_done + 8'd1;
            frame_phase_next     = PH_TYPE;
          end else begin
            frame_remaining_next = frame_remaining - 16'd1;
          end
        end
        default: begin
          frame_phase_next = PH_TYPE;
        end
      endcase
    end

    entry.flags        = flags_held_next;
    entry.session_word = session_held_next;
    entry.sequence_res = sequence_held_next;
    entry.frame_total  = count_held_next;

    if (end_of_buffer) begin
      entry.verdict_valid = 1'b1;
      if (byte_count_next < HDR_LEN) begin
        entry.error_code = ERR_SHORT;
      end else if (magic_seen_next != magic_value) begin
        entry.error_code = ERR_MAGIC;
      end else if (version_seen_next != PROTO_VERSION) begin
        entry.error_code = ERR_VERSION;
      end else if (byte_count_next != HDR_LEN + {1'b0, payload_len_held_next}) begin
        entry.error_code = ERR_LENGTH;
      end else if (frames_done_next < count_held_next) begin
        entry.error_code = (frame_phase_next == PH_DATA) ? ERR_FRAME_DAT : ERR_FRAME_HDR;
      end else begin
        entry.error_code = first_error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_buffer)) begin
      byte_count       <= '0;
      magic_seen       <= '0;
      version_seen     <= '0;
      flags_held       <= '0;
      session_held     <= '0;
      sequence_held    <= '0;
      count_held       <= '0;
      payload_len_held <= '0;
      frame_phase      <= PH_TYPE;
      frames_done      <= '0;
      frame_remaining  <= '0;
      first_error      <= ERR_NONE;
      cur_type         <= '0;
      cur_len          <= '0;
    end else if (accept) begin
      byte_count       <= byte_count_next;
      magic_seen       <= magic_seen_next;
      version_seen     <= version_seen_next;
      flags_held       <= flags_held_next;
      session_held     <= session_held_next;
      sequence_held    <= sequence_held_next;
      count_held       <= count_held_next;
      payload_len_held <= payload_len_held_next;
      frame_phase      <= frame_phase_next;
      frames_done      <= frames_done_next;
      frame_remaining  <= frame_remaining_next;
      first_error      <= first_error_next;
      cur_type         <= cur_type_next;
      cur_len          <= cur_len_next;
    end
  end

endmodule
`default_nettype wire

[sv/pfp_queue.sv]
`default_nettype none
module pfp_queue import pfp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output q_status_t   status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign head         = slots[rd_ptr];
  assign status.full  = (fill == CNT_W'(DEPTH));
  assign status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/pfp_back.sv]
`default_nettype none
module pfp_back import pfp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire entry_t    head,
  input  wire q_status_t q_status,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output result_t        out_result
);

  logic    second, second_next;
  logic    take;
  result_t res;

  assign take = (!out_valid || out_ready) && !q_status.empty;

  always_comb begin
    res              = '0;
    res.flags        = head.flags;
    res.session_word = head.session_word;
    res.sequence_res = head.sequence_res;
    res.frame_total  = head.frame_total;
    pop              = 1'b0;
    second_next      = second;
    if (head.prim_valid && !second) begin
      res.kind          = head.prim_kind;
      res.frame_index   = head.frame_index;
      res.frame_type    = head.frame_type;
      res.frame_length  = head.frame_length;
      res.payload_byte  = head.payload_byte;
      res.last_of_frame = head.last_of_frame;
      res.last_of_run   = !head.verdict_valid;
      // hold the entry for its verdict on the next beat
      pop               = take && !head.verdict_valid;
      second_next       = take ? head.verdict_valid : second;
    end else begin
      res.kind        = (head.error_code != ERR_NONE) ? KIND_REJECT : KIND_ACCEPT;
      res.error_code  = head.error_code;
      res.last_of_run = 1'b1;
      pop             = take;
      second_next     = take ? 1'b0 : second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      second <= second_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_result <= res;
    end
  end

endmodule
`default_nettype wire

[sv/packet_frame_parser.sv]
// Path: each result passes through the result queue and then the output register;
//   a verdict that shares a byte with another result follows as the next beat.
// Throughput: one byte per cycle while the result queue (QUEUE_DEPTH entries) is not full;
//   a byte that yields two results holds the output for two beats, which the queue absorbs.
// Reset: synchronous, active high; clears parse state, queue and output; magic_value -> 0.
`default_nettype none
module packet_frame_parser import pfp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // byte input
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
  input  wire logic         s_tlast,   // end_of_buffer
  // result output
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [7:0] flags, [71:8] session_word, [135:72] sequence_res, [143:136] frame_total,
  // [151:144] frame_index, [159:152] frame_type, [175:160] frame_length,
  // [183:176] payload_byte, [184] last_of_frame, [187:185] error_code, [191:188] zero
  output logic [191:0]      m_tdata,
  output logic [2:0]        m_tuser,   // [2:0] kind
  output logic              m_tlast,   // last_of_run
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic REG_MAGIC = 1'b0;

  logic [15:0] magic_value;
  entry_t      q_in;
  entry_t      q_head;
  q_status_t   q_status;
  logic        q_push;
  logic        q_pop;
  result_t     res;

  // Register file: a single register, magic_value, at byte address 0.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAGIC)) begin
      magic_value <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAGIC) begin
      prdata = {16'h0000, magic_value};
    end
  end

  // Front: parse each byte, update packet state, and queue the results it causes.
  pfp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .data_byte     (s_tdata),
    .end_of_buffer (s_tlast),
    .magic_value   (magic_value),
    .q_status      (q_status),
    .push          (q_push),
    .entry         (q_in)
  );

  // Queue: decouples parsing from delivery so that two-result bytes stall input only when it fills.
  pfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  // Back: split each queued entry into one or two beats into the output register.
  pfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_status   (q_status),
    .pop        (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (res)
  );

  assign m_tuser = res.kind;
  assign m_tlast = res.last_of_run;
  assign m_tdata = {4'h0, res.error_code, res.last_of_frame, res.payload_byte,
                    res.frame_length, res.frame_type, res.frame_index, res.frame_total,
                    res.sequence_res, res.session_word, res.flags};

  // A verdict always closes the run of its byte.
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_ACCEPT || m_tuser == KIND_REJECT) |-> m_tlast)
    else $error("verdict beat without last_of_run");

  // A reject carries a code, every other kind carries none.
  a_error_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == KIND_REJECT) == (m_tdata[187:185] != ERR_NONE)))
    else $error("error code does not match result kind");

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !q_push)
    else $error("push into full result queue");

  // A popped entry was present.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_status.empty |-> !q_pop)
    else $error("pop from empty result queue");

endmodule
`default_nettype wire

[dv/packet_frame_parser_tb.sv]
`default_nettype none
module packet_frame_parser_tb;
  import pfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register map: magic_value is register 0; byte address 4 holds nothing
  localparam logic [2:0] ADDR_MAGIC = 3'd0;
  localparam logic [2:0] ADDR_SPARE = 3'd4;

  // Longest stretch without any beat on either side or the config port
  localparam int QUIET_LIMIT = 2000;
  // Cycles to let the pipeline settle before a register write and at the end
  localparam int SETTLE_CYCLES = 12;
  // Bytes of random packets per magic setting
  localparam int PHASE_BYTES = 80;

  // Packet shapes the generator can build
  typedef enum int {
    SH_GOOD, SH_SHORT, SH_MAGIC, SH_VERSION, SH_LENGTH,
    SH_FRAME_HDR, SH_FRAME_DAT, SH_TRAILING, SH_NOISE
  } shape_t;

  // Frame walk position inside the packet body
  typedef enum logic [1:0] {
    WALK_TYPE, WALK_LEN_HI, WALK_LEN_LO, WALK_DATA
  } walk_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } byte_beat_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;  // [7:0] data_byte
  logic         s_tlast = 1'b0;   // end_of_buffer
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // [7:0] flags, [71:8] session_word, [135:72] sequence_res, [143:136] frame_total,
  // [151:144] frame_index, [159:152] frame_type, [175:160] frame_length,
  // [183:176] payload_byte, [184] last_of_frame, [187:185] error_code
  logic [191:0] m_tdata;
  logic [2:0]   m_tuser;          // [2:0] kind
  logic         m_tlast;          // last_of_run
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = 3'd0;
  logic [31:0]  pwdata = 32'd0;
  logic [31:0]  prdata;
  logic         pready;

  packet_frame_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror: header fields, frame walk and the sticky trailing flag,
  // updated once per accepted byte beat.
  // ---------------------------------------------------------------------------
  logic [15:0] magic_cfg = 16'h0000;
  logic [16:0] pk_count;
  logic [15:0] seen_magic;
  logic [7:0]  seen_version;
  logic [7:0]  hdr_flags;
  logic [63:0] hdr_session;
  logic [63:0] hdr_seq;
  logic [7:0]  hdr_frames;
  logic [15:0] hdr_paylen;
  walk_t       walk;
  logic [7:0]  frames_seen;
  logic [15:0] bytes_left;
  logic [2:0]  sticky_err;
  logic [7:0]  cur_type;
  logic [15:0] cur_len;

  result_t expected_results[$];
  int      fails = 0;

  task automatic restart_packet();
    pk_count     = '0;
    seen_magic   = '0;
    seen_version = '0;
    hdr_flags    = '0;
    hdr_session  = '0;
    hdr_seq      = '0;
    hdr_frames   = '0;
    hdr_paylen   = '0;
    walk         = WALK_TYPE;
    frames_seen  = '0;
    bytes_left   = '0;
    sticky_err   = ERR_NONE;
    cur_type     = '0;
    cur_len      = '0;
  endtask

  // Every result carries the held header; frame fields only for frame/data kinds
  function automatic result_t held_result(input logic [2:0] kind, input logic with_frame,
                                          input logic [7:0] pbyte, input logic lastf,
                                          input logic [2:0] code);
    result_t r;
    r.kind          = kind;
    r.flags         = hdr_flags;
    r.session_word  = hdr_session;
    r.sequence_res  = hdr_seq;
    r.frame_total   = hdr_frames;
    r.frame_index   = with_frame ? frames_seen : 8'h00;
    r.frame_type    = with_frame ? cur_type : 8'h00;
    r.frame_length  = with_frame ? cur_len : 16'h0000;
    r.payload_byte  = pbyte;
    r.last_of_frame = lastf;
    r.error_code    = code;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic eob);
    result_t     res [2];
    int          k;
    logic [16:0] n;
    logic [2:0]  code;
    logic        endf;
    k = 0;
    n = pk_count;
    // Saturate rather than wrap, so an oversized packet can never look short
    if (n != COUNT_MAX) pk_count = n + 17'd1;

    if (n < HDR_LEN) begin
      if (n < OFS_VERSION) seen_magic = {seen_magic[7:0], b};
      else if (n == OFS_VERSION) seen_version = b;
      else if (n == OFS_FLAGS) hdr_flags = b;
      else if (n < OFS_SEQUENCE) hdr_session = {hdr_session[55:0], b};
      else if (n < OFS_COUNT) hdr_seq = {hdr_seq[55:0], b};
      else if (n == OFS_COUNT) hdr_frames = b;
      else hdr_paylen = {hdr_paylen[7:0], b};
      // Header result goes out on the last header byte, checks or not
      if (n == HDR_LEN - 17'd1) begin
        res[k] = held_result(KIND_HEADER, 1'b0, 8'h00, 1'b0, ERR_NONE);
        k++;
      end
    end else if (frames_seen >= hdr_frames) begin
      // Byte past the last declared frame: remember it, emit nothing
      if (sticky_err == ERR_NONE) sticky_err = ERR_TRAILING;
    end else begin
      case (walk)
        WALK_TYPE: begin
          cur_type = b;
          walk = WALK_LEN_HI;
        end
        WALK_LEN_HI: begin
          cur_len = {b, 8'h00};
          walk = WALK_LEN_LO;
        end
        WALK_LEN_LO: begin
          cur_len = {cur_len[15:8], b};
          res[k] = held_result(KIND_FRAME, 1'b1, 8'h00, 1'b0, ERR_NONE);
          k++;
          // A zero-length frame closes right away
          if (cur_len == 16'h0000) begin
            frames_seen = frames_seen + 8'd1;
            walk = WALK_TYPE;
          end else begin
            bytes_left = cur_len;
            walk = WALK_DATA;
          end
        end
        default: begin
          endf = (bytes_left <= 16'd1);
          res[k] = held_result(KIND_DATA, 1'b1, b, endf, ERR_NONE);
          k++;
          if (endf) begin
            bytes_left = '0;
            frames_seen = frames_seen + 8'd1;
            walk = WALK_TYPE;
          end else begin
            bytes_left = bytes_left - 16'd1;
          end
        end
      endcase
    end

    if (eob) begin
      // Verdict: first failing check in fixed order
      if (pk_count < HDR_LEN) code = ERR_SHORT;
      else if (seen_magic != magic_cfg) code = ERR_MAGIC;
      else if (seen_version != PROTO_VERSION) code = ERR_VERSION;
      else if (pk_count != HDR_LEN + {1'b0, hdr_paylen}) code = ERR_LENGTH;
      else if (frames_seen < hdr_frames)
        code = (walk == WALK_DATA) ? ERR_FRAME_DAT : ERR_FRAME_HDR;
      else code = sticky_err;
      res[k] = held_result((code == ERR_NONE) ? KIND_ACCEPT : KIND_REJECT,
                           1'b0, 8'h00, 1'b0, code);
      k++;
      restart_packet();
    end

    if (k > 0) res[k-1].last_of_run = 1'b1;
    for (int i = 0; i < k; i++) expected_results.insert(expected_results.size(), res[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: pop pending beats, hold each until taken, idle for a random
  // send_gap between beats except during burst stretches.
  // ---------------------------------------------------------------------------
  byte_beat_t pending_bytes[$];
  byte_beat_t send_beat;
  int         send_gap = 0;
  bit         send_burst = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
      // Advance only when the current beat is gone or none is up
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          send_beat = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= send_beat.data;
          s_tlast  <= send_beat.eob;
          if ($urandom_range(0, 47) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 4);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each taken beat with the oldest expectation and
  // stall for a random recv_stall after each one, again with burst stretches.
  // ---------------------------------------------------------------------------
  int recv_stall = 0;
  bit recv_burst = 1'b0;

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic compare_result();
    result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0d data %0h",
               $time, m_tuser, m_tdata);
      fails++;
    end else begin
      want = expected_results.pop_front();
      check_field("kind",          64'(want.kind),          64'(m_tuser));
      check_field("flags",         64'(want.flags),         64'(m_tdata[7:0]));
      check_field("session_word",  want.session_word,       m_tdata[71:8]);
      check_field("sequence_res",  want.sequence_res,       m_tdata[135:72]);
      check_field("frame_total",   64'(want.frame_total),   64'(m_tdata[143:136]));
      check_field("frame_index",   64'(want.frame_index),   64'(m_tdata[151:144]));
      check_field("frame_type",    64'(want.frame_type),    64'(m_tdata[159:152]));
      check_field("frame_length",  64'(want.frame_length),  64'(m_tdata[175:160]));
      check_field("payload_byte",  64'(want.payload_byte),  64'(m_tdata[183:176]));
      check_field("last_of_frame", 64'(want.last_of_frame), 64'(m_tdata[184]));
      check_field("error_code",    64'(want.error_code),    64'(m_tdata[187:185]));
      check_field("last_of_run",   64'(want.last_of_run),   64'(m_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        compare_result();
        if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 4);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      m_tready <= (recv_stall == 0);
    end
  end

  // Watchdog: end the run if no beat moves anywhere for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Packet generator
  // ---------------------------------------------------------------------------
  logic [7:0] frame_bytes[$];
  logic [7:0] packet_bytes[$];
  int         bytes_queued = 0;

  // Mostly random, with a fair share of all-zero and all-one values
  function automatic logic [63:0] pick_edge();
    case ($urandom_range(0, 5))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic put_frame(input logic [15:0] flen, input int ndata);
    frame_bytes.insert(frame_bytes.size(), 8'(pick_edge()));
    frame_bytes.insert(frame_bytes.size(), flen[15:8]);
    frame_bytes.insert(frame_bytes.size(), flen[7:0]);
    for (int i = 0; i < ndata; i++) frame_bytes.insert(frame_bytes.size(), 8'(pick_edge()));
  endtask

  // Build one packet of the given shape and queue its beats. push_limit drives
  // the field at stake to its top value: frame count 255 for a header overrun,
  // frame length 65535 for a data overrun, payload length 65535 for a mismatch.
  task automatic send_packet(input shape_t shape, input int n_frames, input int max_len,
                             input bit push_limit);
    logic [15:0] mg;
    logic [15:0] plen;
    logic [15:0] flen;
    logic [7:0]  ver;
    logic [7:0]  cnt;
    logic [63:0] sess;
    logic [63:0] seq;
    int          keep;
    byte_beat_t  beat;
    frame_bytes.delete();
    packet_bytes.delete();
    mg   = magic_cfg;
    ver  = PROTO_VERSION;
    cnt  = n_frames[7:0];
    sess = pick_edge();
    seq  = pick_edge();

    for (int f = 0; f < n_frames; f++) begin
      flen = 16'($urandom_range(0, max_len));
      put_frame(flen, int'(flen));
    end

    case (shape)
      SH_MAGIC:   mg = mg ^ 16'($urandom_range(1, 65535));
      SH_VERSION: ver = 8'($urandom_range(2, 256));
      SH_FRAME_HDR: begin
        // Declare more frames than follow; end before or inside the next header
        cnt = push_limit ? 8'hFF : 8'(n_frames + 1 + $urandom_range(0, 2));
        keep = $urandom_range(0, 2);
        for (int i = 0; i < keep; i++)
          frame_bytes.insert(frame_bytes.size(), 8'(pick_edge()));
      end
      SH_FRAME_DAT: begin
        // Open one more frame and cut its data short
        cnt = 8'(n_frames + 1 + $urandom_range(0, 1));
        flen = push_limit ? 16'hFFFF : 16'($urandom_range(1, 16));
        put_frame(flen, $urandom_range(0, (flen > 16'd8) ? 8 : flen - 1));
      end
      SH_TRAILING: begin
        keep = $urandom_range(1, 4);
        for (int i = 0; i < keep; i++)
          frame_bytes.insert(frame_bytes.size(), 8'(pick_edge()));
      end
      default: ;
    endcase

    plen = 16'(frame_bytes.size());
    if (shape == SH_LENGTH)
      plen = (push_limit && plen != 16'hFFFF) ? 16'hFFFF : plen + 16'($urandom_range(1, 65535));

    if (shape == SH_NOISE) begin
      keep = $urandom_range(1, 40);
      for (int i = 0; i < keep; i++) packet_bytes.insert(packet_bytes.size(), 8'($urandom));
    end else begin
      packet_bytes.insert(packet_bytes.size(), mg[15:8]);
      packet_bytes.insert(packet_bytes.size(), mg[7:0]);
      packet_bytes.insert(packet_bytes.size(), ver);
      packet_bytes.insert(packet_bytes.size(), 8'(pick_edge()));
      for (int i = 7; i >= 0; i--) packet_bytes.insert(packet_bytes.size(), sess[8*i +: 8]);
      for (int i = 7; i >= 0; i--) packet_bytes.insert(packet_bytes.size(), seq[8*i +: 8]);
      packet_bytes.insert(packet_bytes.size(), cnt);
      packet_bytes.insert(packet_bytes.size(), plen[15:8]);
      packet_bytes.insert(packet_bytes.size(), plen[7:0]);
      foreach (frame_bytes[i]) packet_bytes.insert(packet_bytes.size(), frame_bytes[i]);
      // Short packet: drop everything past a random point inside the header
      if (shape == SH_SHORT) begin
        keep = $urandom_range(1, 22);
        while (packet_bytes.size() > keep) void'(packet_bytes.pop_back());
      end
    end

    foreach (packet_bytes[i]) begin
      beat.data = packet_bytes[i];
      beat.eob  = (i == packet_bytes.size() - 1);
      pending_bytes.insert(pending_bytes.size(), beat);
    end
    bytes_queued += packet_bytes.size();
  endtask

  function automatic shape_t pick_shape();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      11: return SH_SHORT;
      12: return SH_MAGIC;
      13: return SH_VERSION;
      14: return SH_LENGTH;
      15: return SH_FRAME_HDR;
      16: return SH_FRAME_DAT;
      17: return SH_TRAILING;
      18, 19: return SH_NOISE;
      default: return SH_GOOD;
    endcase
  endfunction

  // Wait until every queued byte is taken and every result checked, then let
  // any result-free bytes still in the pipeline settle.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle held until pready
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MAGIC) magic_cfg = data[15:0];
  endtask

  task automatic random_phase(input logic [15:0] magic);
    int start;
    wait_drained();
    // Junk in the upper half of pwdata must not reach the register
    apb_write(ADDR_MAGIC, {16'($urandom), magic});
    start = bytes_queued;
    while (bytes_queued - start < PHASE_BYTES)
      send_packet(pick_shape(), $urandom_range(0, 3) +
                  (($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 0),
                  ($urandom_range(0, 3) == 0) ? 40 : 8, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    restart_packet();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset magic is zero: header-only packet accepted on its last header byte
    send_packet(SH_GOOD, 0, 0, 1'b0);
    send_packet(SH_SHORT, 0, 0, 1'b0);

    wait_drained();
    apb_write(ADDR_MAGIC, 32'hA5A5_FFFF);
    // Zero-length frame ending the packet: frame start and verdict on one byte
    send_packet(SH_GOOD, 1, 0, 1'b0);
    send_packet(SH_GOOD, 2, 6, 1'b0);
    send_packet(SH_MAGIC, 1, 3, 1'b0);
    send_packet(SH_VERSION, 1, 3, 1'b0);
    send_packet(SH_LENGTH, 1, 4, 1'b1);
    send_packet(SH_FRAME_HDR, 0, 0, 1'b1);
    send_packet(SH_FRAME_HDR, 2, 3, 1'b0);
    send_packet(SH_FRAME_DAT, 1, 2, 1'b1);
    send_packet(SH_FRAME_DAT, 0, 0, 1'b0);
    send_packet(SH_TRAILING, 1, 2, 1'b0);
    send_packet(SH_NOISE, 0, 0, 1'b0);
    // Full frame count of zero-length frames, frame index up to 254
    send_packet(SH_GOOD, 255, 0, 1'b0);

    // Write to a register that does not exist; magic must stay put
    wait_drained();
    apb_write(ADDR_SPARE, $urandom);
    send_packet(SH_GOOD, 1, 5, 1'b0);

    random_phase(16'h00FF);
    random_phase(16'($urandom));
    random_phase(16'hFF00);
    random_phase(16'($urandom));
    random_phase(16'h0000);

    wait_drained();
    foreach (expected_results[i]) begin
      $display("%0t: missing result: expected kind %0d, actual none",
               $time, expected_results[i].kind);
      fails++;
    end
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
sv/pfp_pkg.sv
sv/pfp_front.sv
sv/pfp_queue.sv
sv/pfp_back.sv
sv/packet_frame_parser.sv
dv/packet_frame_parser_tb.sv
